// ===== hdl/priority_deque_job_server_top_macros.svh =====
// Assertion helpers shared by the job server modules.
// Both expect clk and rst_n in scope.
`ifndef PRIORITY_DEQUE_JOB_SERVER_TOP_MACROS_SVH
`define PRIORITY_DEQUE_JOB_SERVER_TOP_MACROS_SVH

// Same-cycle implication.
`define PDJS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PDJS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pdjs_pkg.sv =====
package pdjs_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int WAIT_W          = 5;

    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_NORMAL = 2'd1;
    localparam logic [1:0] FUNC_URGENT = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] course_id;
        logic [7:0] person_id;
        logic [7:0] job_minutes;
    } in_t;

    typedef struct packed {
        logic              serving;
        logic              urgent;
        logic [7:0]        served_course;
        logic [7:0]        served_person;
        logic [7:0]        time_left;
        logic [31:0]       tick_number;
        logic              dropped;
        logic [WAIT_W-1:0] waiting;
    } out_t;

    typedef struct packed {
        logic       urgent;
        logic [7:0] course;
        logic [7:0] person;
        logic [7:0] minutes;
    } entry_t;

    // Per-tick commands to the deque.
    typedef struct packed {
        logic advance;
        logic push;
        logic urgent;
        logic pop;
    } deq_ctl_t;

endpackage

// ===== hdl/pdjs_deque.sv =====
`include "priority_deque_job_server_top_macros.svh"

module pdjs_deque
    import pdjs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  deq_ctl_t         ctl,
    input  entry_t           wr_entry,
    output logic [CNT_W-1:0] count,
    output entry_t           front
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    entry_t mem [QUEUE_DEPTH];

    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    entry_t           rd_data_reg;
    entry_t           fwd_data_reg;
    logic             fwd_reg;

    logic [IDX_W-1:0] head_dec;
    logic [IDX_W-1:0] head_ins;
    logic [IDX_W-1:0] head_ins_inc;
    logic [IDX_W:0]   tail_sum;
    logic [IDX_W-1:0] tail;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;

    always_comb
    begin
        head_dec = (head_reg == '0) ? IDX_W'(QUEUE_DEPTH - 1) : head_reg - 1'b1;
        tail_sum = {1'b0, head_reg} + (IDX_W + 1)'(count_reg);
        if (tail_sum >= (IDX_W + 1)'(QUEUE_DEPTH))
        begin
            tail = IDX_W'(tail_sum - (IDX_W + 1)'(QUEUE_DEPTH));
        end
        else
        begin
            tail = tail_sum[IDX_W-1:0];
        end

        head_ins     = (ctl.push && ctl.urgent) ? head_dec : head_reg;
        head_ins_inc = (head_ins == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ins + 1'b1;
        head_next    = ctl.pop ? head_ins_inc : head_ins;
        count_next   = CNT_W'(count_reg + CNT_W'(ctl.push) - CNT_W'(ctl.pop));

        wr_en   = ctl.advance && ctl.push;
        wr_addr = ctl.urgent ? head_dec : tail;
        rd_addr = ctl.advance ? head_next : head_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            fwd_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.advance)
            begin
                head_reg  <= head_next;
                count_reg <= count_next;
            end
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    // Front slot is prefetched; a write into that slot on the same edge is forwarded.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        rd_data_reg  <= mem[rd_addr];
        fwd_data_reg <= wr_entry;
    end

    assign count = count_reg;
    assign front = fwd_reg ? fwd_data_reg : rd_data_reg;

    `PDJS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH),
        "deque count beyond depth")
    `PDJS_ASSERT_NOW(a_no_push_full, ctl.advance && ctl.push,
        count_reg < CNT_W'(QUEUE_DEPTH), "push into full deque")
    `PDJS_ASSERT_NOW(a_no_pop_empty, ctl.advance && ctl.pop,
        count_reg != '0 || ctl.push, "pop from empty deque")
    `PDJS_ASSERT_NEXT(a_idle_hold, !ctl.advance,
        $stable(count_reg) && $stable(head_reg), "deque moved without a tick")

endmodule

// ===== hdl/priority_deque_job_server_top.sv =====
// Non-preemptive job server with a priority deque. Each input transfer is one
// tick: normal requests join the back of a ring deque, urgent ones the front, and
// when the current job has run out the front entry is taken on. Exactly one result
// leaves per tick. One tick is accepted every cycle unless a waiting result is not
// taken (out_ready low); a tick passes the input register, then the result register,
// and the deque front is kept prefetched so a pop needs no memory read. The deque holds
// QUEUE_DEPTH entries; a request arriving while it is full is dropped and flagged.
`include "priority_deque_job_server_top_macros.svh"

module priority_deque_job_server_top
    import pdjs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic        in_valid_reg;
    in_t         in_data_reg;
    logic        out_valid_reg;
    out_t        out_data_reg;
    out_t        out_data_next;
    entry_t      cur_reg;
    entry_t      cur_next;
    logic [31:0] tick_reg;

    logic             advance;
    logic             is_req;
    logic             push_ok;
    logic             pop;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] count_ins;
    logic [CNT_W-1:0] count_after;
    entry_t           req;
    entry_t           front;
    entry_t           job;
    deq_ctl_t         deq_ctl;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        is_req      = (in_data_reg.func == FUNC_NORMAL) || (in_data_reg.func == FUNC_URGENT);
        push_ok     = is_req && (count < CNT_W'(QUEUE_DEPTH));
        req.urgent  = (in_data_reg.func == FUNC_URGENT);
        req.course  = in_data_reg.course_id;
        req.person  = in_data_reg.person_id;
        req.minutes = in_data_reg.job_minutes;

        count_ins   = CNT_W'(count + CNT_W'(push_ok));
        pop         = (cur_reg.minutes == 8'd0) && (count_ins != '0);
        count_after = CNT_W'(count_ins - CNT_W'(pop));

        // The new request is the front when it went in at the front or the deque was empty
        if (pop)
        begin
            job = (push_ok && (req.urgent || count == '0)) ? req : front;
        end
        else
        begin
            job = cur_reg;
        end

        cur_next      = job;
        out_data_next = '0;
        if (job.minutes != 8'd0)
        begin
            out_data_next.serving       = 1'b1;
            out_data_next.urgent        = job.urgent;
            out_data_next.served_course = job.course;
            out_data_next.served_person = job.person;
            out_data_next.time_left     = job.minutes;
            cur_next.minutes            = job.minutes - 8'd1;
        end
        out_data_next.tick_number = tick_reg;
        out_data_next.dropped     = is_req && !push_ok;
        out_data_next.waiting     = WAIT_W'(count_after);

        deq_ctl.advance = advance;
        deq_ctl.push    = push_ok;
        deq_ctl.urgent  = req.urgent;
        deq_ctl.pop     = pop;
    end

    pdjs_deque #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CNT_W       (CNT_W)
    ) u_deque (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (deq_ctl),
        .wr_entry (req),
        .count    (count),
        .front    (front)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_reg       <= '0;
            tick_reg      <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                cur_reg       <= cur_next;
                tick_reg      <= tick_reg + 32'd1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `PDJS_ASSERT_NEXT(a_tick_step, advance, tick_reg == $past(tick_reg) + 32'd1,
        "tick counter missed a step")
    `PDJS_ASSERT_NEXT(a_tick_hold, !advance, $stable(tick_reg),
        "tick counter moved while stalled")
    `PDJS_ASSERT_NOW(a_serve_time, out_valid_reg && out_data_reg.serving,
        out_data_reg.time_left != 8'd0, "served job with no time left")
    `PDJS_ASSERT_NOW(a_drop_full, advance && out_data_next.dropped,
        count == CNT_W'(QUEUE_DEPTH), "request dropped with room in deque")

endmodule

// ===== dv/priority_deque_job_server_top_tb.sv =====
`timescale 1ns / 1ps

module priority_deque_job_server_top_tb;
    import pdjs_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam int RANDOM_TICKS = 1450;
    localparam int PAUSE_AT = 700;
    localparam int CALM_FROM = 600;
    localparam int CALM_TO = 1000;
    localparam int TAIL_CYCLES = 20;
    localparam int CYCLE_LIMIT = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;

    in_t pending_ticks[$];
    out_t expected_reports[$];

    // scheduler mirror
    entry_t waiting_mem[DEPTH];
    int front_idx = 0;
    int queued = 0;
    entry_t on_server = '0;
    logic [31:0] tick_cnt = '0;

    int ticks_accepted = 0;
    int reports_seen = 0;
    int cycle_cnt = 0;
    int fault_cnt = 0;
    int served_ticks = 0;
    int urgent_ticks = 0;
    int drop_ticks = 0;
    int full_ticks = 0;

    priority_deque_job_server_top #(
        .QUEUE_DEPTH(DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_fault(input string msg);
        $display("ERROR: %s", msg);
        fault_cnt++;
    endtask

    function automatic in_t mk_tick(input logic [1:0] f, input logic [7:0] c,
                                    input logic [7:0] p, input logic [7:0] m);
        in_t t;
        t.func = f;
        t.course_id = c;
        t.person_id = p;
        t.job_minutes = m;
        return t;
    endfunction

    task automatic queue_tick(input in_t t);
        pending_ticks = {pending_ticks, t};
    endtask

    // mostly short jobs so the deque drains as well as fills
    function automatic logic [7:0] pick_minutes();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 8'd0;
        else if (r < 90)
            return 8'($urandom_range(1, 3));
        else if (r < 99)
            return 8'($urandom_range(4, 12));
        else
            return 8'($urandom_range(13, 255));
    endfunction

    function automatic bit take_break();
        return (cycle_cnt < CALM_FROM || cycle_cnt >= CALM_TO) && ($urandom_range(0, 99) < 8);
    endfunction

    // one tick of the scheduler: insert, refill server, serve and decrement
    task automatic schedule_tick(input in_t t);
        entry_t req;
        out_t rep;
        logic drop;
        int slot;
        req.urgent = (t.func == FUNC_URGENT);
        req.course = t.course_id;
        req.person = t.person_id;
        req.minutes = t.job_minutes;
        drop = 1'b0;
        if (t.func == FUNC_NORMAL || t.func == FUNC_URGENT)
        begin
            if (queued >= DEPTH)
                drop = 1'b1;
            else if (t.func == FUNC_URGENT)
            begin
                front_idx = (front_idx + DEPTH - 1) % DEPTH;
                waiting_mem[front_idx] = req;
                queued++;
            end
            else
            begin
                slot = (front_idx + queued) % DEPTH;
                waiting_mem[slot] = req;
                queued++;
            end
        end
        if (on_server.minutes == 8'd0 && queued > 0)
        begin
            on_server = waiting_mem[front_idx];
            front_idx = (front_idx + 1) % DEPTH;
            queued--;
        end
        rep = '0;
        if (on_server.minutes != 8'd0)
        begin
            rep.serving = 1'b1;
            rep.urgent = on_server.urgent;
            rep.served_course = on_server.course;
            rep.served_person = on_server.person;
            rep.time_left = on_server.minutes;
            on_server.minutes = on_server.minutes - 8'd1;
        end
        rep.tick_number = tick_cnt;
        rep.dropped = drop;
        rep.waiting = queued[WAIT_W-1:0];
        tick_cnt = tick_cnt + 32'd1;
        expected_reports = {expected_reports, rep};
    endtask

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // driver; holds off once at PAUSE_AT until every report is back
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                schedule_tick(in_data);
                ticks_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_ticks.size() == 0 || take_break() ||
                    (ticks_accepted == PAUSE_AT && reports_seen != ticks_accepted))
                    in_valid <= 1'b0;
                else
                begin
                    in_data <= pending_ticks[0];
                    pending_ticks.delete(0);
                    in_valid <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        out_t want;
        out_t got;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                reports_seen <= reports_seen + 1;
                got = out_data;
                if (expected_reports.size() == 0)
                    report_fault($sformatf("result with none pending, tick_number %0d",
                                           got.tick_number));
                else
                begin
                    want = expected_reports[0];
                    expected_reports.delete(0);
                    if (got.serving !== want.serving)
                        report_fault($sformatf("tick %0d serving got %0h want %0h",
                                               want.tick_number, got.serving, want.serving));
                    if (got.urgent !== want.urgent)
                        report_fault($sformatf("tick %0d urgent got %0h want %0h",
                                               want.tick_number, got.urgent, want.urgent));
                    if (got.served_course !== want.served_course)
                        report_fault($sformatf("tick %0d served_course got %0h want %0h",
                                               want.tick_number, got.served_course,
                                               want.served_course));
                    if (got.served_person !== want.served_person)
                        report_fault($sformatf("tick %0d served_person got %0h want %0h",
                                               want.tick_number, got.served_person,
                                               want.served_person));
                    if (got.time_left !== want.time_left)
                        report_fault($sformatf("tick %0d time_left got %0h want %0h",
                                               want.tick_number, got.time_left,
                                               want.time_left));
                    if (got.tick_number !== want.tick_number)
                        report_fault($sformatf("tick %0d tick_number got %0h",
                                               want.tick_number, got.tick_number));
                    if (got.dropped !== want.dropped)
                        report_fault($sformatf("tick %0d dropped got %0h want %0h",
                                               want.tick_number, got.dropped, want.dropped));
                    if (got.waiting !== want.waiting)
                        report_fault($sformatf("tick %0d waiting got %0d want %0d",
                                               want.tick_number, got.waiting, want.waiting));
                    served_ticks += want.serving;
                    urgent_ticks += want.urgent;
                    drop_ticks += want.dropped;
                    full_ticks += (want.waiting == DEPTH);
                end
            end
            out_ready <= !take_break();
        end
    end

    initial
    begin
        int n_random;
        int burst;
        int mode;
        int i;
        int k;
        logic [1:0] f;

        // idle ticks, spare selector with all ones, then a short job and a long urgent one
        queue_tick(mk_tick(FUNC_TICK, 8'h00, 8'h00, 8'h00));
        queue_tick(mk_tick(FUNC_SPARE, 8'hFF, 8'hFF, 8'hFF));
        queue_tick(mk_tick(FUNC_NORMAL, 8'hFF, 8'h00, 8'd2));
        queue_tick(mk_tick(FUNC_URGENT, 8'h00, 8'hFF, 8'hFF));
        queue_tick(mk_tick(FUNC_NORMAL, 8'h5A, 8'hA5, 8'd0));
        // fill the deque behind the long job, then overflow it from both ends
        for (i = 0; i < DEPTH - 1; i++)
        begin
            f = i[0] ? FUNC_URGENT : FUNC_NORMAL;
            queue_tick(mk_tick(f, 8'(i * 17), 8'(255 - i * 17),
                               (i % 5 == 0) ? 8'd0 : 8'(i)));
        end
        queue_tick(mk_tick(FUNC_NORMAL, 8'hC3, 8'h3C, 8'd1));
        queue_tick(mk_tick(FUNC_URGENT, 8'h3C, 8'hC3, 8'd1));

        n_random = 0;
        while (n_random < RANDOM_TICKS)
        begin
            mode = $urandom_range(0, 9);
            burst = $urandom_range(8, 60);
            for (k = 0; k < burst; k++)
            begin
                if (mode < 3)
                    f = ($urandom_range(0, 99) < 80) ?
                        ($urandom_range(0, 1) ? FUNC_URGENT : FUNC_NORMAL) : FUNC_TICK;
                else if (mode < 7)
                    f = ($urandom_range(0, 99) < 5) ? FUNC_NORMAL : FUNC_TICK;
                else if (mode < 8)
                    f = ($urandom_range(0, 99) < 30) ?
                        ($urandom_range(0, 1) ? FUNC_URGENT : FUNC_NORMAL) : FUNC_TICK;
                else
                    f = 2'($urandom_range(0, 3));
                queue_tick(mk_tick(f, 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)), pick_minutes()));
                n_random++;
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ticks.size() != 0 || in_valid || ticks_accepted != reports_seen)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_reports.size() != 0)
            report_fault($sformatf("%0d reports never arrived", expected_reports.size()));

        $display("ran %0d ticks: %0d with a job in service, %0d of them urgent",
                 ticks_accepted, served_ticks, urgent_ticks);
        $display("%0d requests dropped, %0d ticks ended with the deque full, %0d faults",
                 drop_ticks, full_ticks, fault_cnt);
        if (fault_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== priority_deque_job_server_top.f =====
+incdir+hdl
hdl/pdjs_pkg.sv
hdl/pdjs_deque.sv
hdl/priority_deque_job_server_top.sv
dv/priority_deque_job_server_top_tb.sv
